[rtl/ftp_pkg.sv]
// ----------------------------------------------------------------------------
// ftp_pkg
// Shared types, codes and controller/datapath handshake structs for the
// binary indexed tree prefix-sum engine.
// ----------------------------------------------------------------------------
package ftp_pkg;

	localparam int MAX_POSITIONS_DEF = 1024;
	localparam int IDX_W             = 11;
	localparam int DATA_W            = 32;
	localparam int KIND_W            = 2;
	localparam int APB_AW            = 3;
	localparam int APB_DW            = 32;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DATA_W-1:0] word_t;

	// operation codes carried in the kind field
	localparam kind_t KIND_ADD   = 2'd0;
	localparam kind_t KIND_QUERY = 2'd1;
	localparam kind_t KIND_FIND  = 2'd2;

	// register word index within the APB window (paddr[2])
	localparam logic REG_ACTIVE_SIZE = 1'b0;
	localparam idx_t ACTIVE_SIZE_RST = 11'd1024;

	// controller to datapath
	typedef struct packed {
		logic idle;      // ready for a new beat
		logic clr_wr;    // write one entry of the reset sweep
		logic add_rd;    // read node for an add
		logic add_wr;    // write node plus delta, climb the tree
		logic sum_rd;    // read node for a prefix sum, strip low bit
		logic find_mid;  // load midpoint of the search window
		logic find_cmp;  // compare prefix sum with target, narrow window
		logic load_out;  // move result into the output register
	} ftp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  req_valid;
		kind_t req_kind;
		kind_t cur_kind;
		logic  clr_last;
		logic  add_skip;
		logic  idx_zero;
		logic  rd_vld;
		logic  search_done;
		logic  out_busy;
	} ftp_sts_t;

endpackage

[rtl/ftp_if.sv]
// ----------------------------------------------------------------------------
// ftp_req_if / ftp_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface ftp_req_if;
	import ftp_pkg::*;

	logic               valid;
	logic               ready;
	kind_t              kind;
	idx_t               entry_index;
	logic signed [31:0] delta;
	logic signed [31:0] target_sum;

	modport source (output valid, kind, entry_index, delta, target_sum, input ready);
	modport sink   (input valid, kind, entry_index, delta, target_sum, output ready);
endinterface

interface ftp_rsp_if;
	import ftp_pkg::*;

	logic               valid;
	logic               ready;
	logic signed [31:0] prefix_sum;
	idx_t               found_index;
	logic               found;

	modport source (output valid, prefix_sum, found_index, found, input ready);
	modport sink   (input valid, prefix_sum, found_index, found, output ready);
endinterface

[rtl/ftp_ram.sv]
// ----------------------------------------------------------------------------
// ftp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ftp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/ftp_ctrl.sv]
// ----------------------------------------------------------------------------
// ftp_ctrl
// Sequencer: reset sweep, add climb, prefix-sum descent and binary search.
// ----------------------------------------------------------------------------
module ftp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ftp_pkg::ftp_sts_t sts,
	output ftp_pkg::ftp_cmd_t cmd
);
	import ftp_pkg::*;

	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_ADD_RD = 3'd2;
	localparam logic [2:0] S_ADD_WR = 3'd3;
	localparam logic [2:0] S_SUM    = 3'd4;
	localparam logic [2:0] S_FSTEP  = 3'd5;
	localparam logic [2:0] S_FCMP   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.req_valid) begin
					priority case (sts.req_kind)
						KIND_ADD:   state_d = S_ADD_RD;
						KIND_QUERY: state_d = S_SUM;
						KIND_FIND:  state_d = S_FSTEP;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_ADD_RD: begin
				if (sts.add_skip) begin
					state_d = S_DONE;
				end else begin
					cmd.add_rd = 1'b1;
					state_d    = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_ADD_RD;
			end
			S_SUM: begin
				// issue reads until the index runs out, then drain the last one
				if (!sts.idx_zero) begin
					cmd.sum_rd = 1'b1;
				end else if (!sts.rd_vld) begin
					state_d = (sts.cur_kind == KIND_FIND) ? S_FCMP : S_DONE;
				end
			end
			S_FSTEP: begin
				if (sts.search_done) begin
					state_d = S_DONE;
				end else begin
					cmd.find_mid = 1'b1;
					state_d      = S_SUM;
				end
			end
			S_FCMP: begin
				cmd.find_cmp = 1'b1;
				state_d      = S_FSTEP;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	a_add_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD_WR |-> $past(state_q) == S_ADD_RD)
		else $error("add write without preceding read");

	a_cmp_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FCMP |-> $past(state_q) == S_SUM && sts.cur_kind == KIND_FIND)
		else $error("search compare outside a find");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !sts.rd_vld)
		else $error("read still in flight when idle");

endmodule

[rtl/ftp_dp.sv]
// ----------------------------------------------------------------------------
// ftp_dp
// Datapath: node memory, working index, accumulator, search window and
// output register.
// ----------------------------------------------------------------------------
module ftp_dp #(
	parameter int MAX_POSITIONS = ftp_pkg::MAX_POSITIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ftp_pkg::idx_t     active_size,
	input  ftp_pkg::ftp_cmd_t cmd,
	output ftp_pkg::ftp_sts_t sts,
	ftp_req_if.sink           req,
	ftp_rsp_if.source         rsp
);
	import ftp_pkg::*;

	localparam int AW = $clog2(MAX_POSITIONS);
	localparam int IW = $clog2(MAX_POSITIONS + 1);
	// room for index plus low bit and for lo + hi
	localparam int XW = ((IW > IDX_W) ? IW : IDX_W) + 1;

	logic          start;
	logic [XW-1:0] eff;
	logic [XW-1:0] req_idx;
	logic [XW-1:0] req_idx_sat;
	logic [XW-1:0] lb;
	logic [XW-1:0] lo_hi;
	logic [IW-1:0] clr_idx;
	logic [IW-1:0] clr_lb;
	logic [AW-1:0] node_addr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	word_t         ram_wdata;
	word_t         rdata;

	kind_t         kind_q;
	logic [XW-1:0] idx_q;
	word_t         delta_q;
	word_t         target_q;
	word_t         acc_q;
	logic [XW-1:0] lo_q;
	logic [XW-1:0] hi_q;
	logic [XW-1:0] mid_q;
	logic [XW-1:0] pos_q;
	logic          hit_q;
	logic [AW-1:0] clr_q;
	logic          rd_vld_s1;
	logic          out_vld_q;
	word_t         out_sum_q;
	idx_t          out_idx_q;
	logic          out_hit_q;

	assign start       = req.valid && cmd.idle;
	assign req.ready   = cmd.idle;
	assign eff         = (XW'(active_size) > XW'(MAX_POSITIONS)) ?
	                     XW'(MAX_POSITIONS) : XW'(active_size);
	assign req_idx     = XW'(req.entry_index);
	assign req_idx_sat = (req_idx > XW'(MAX_POSITIONS)) ? XW'(MAX_POSITIONS) : req_idx;
	assign lb          = idx_q & (~idx_q + XW'(1));
	assign lo_hi       = lo_q + hi_q;
	assign clr_idx     = IW'(clr_q) + IW'(1);
	assign clr_lb      = clr_idx & (~clr_idx + IW'(1));
	assign node_addr   = AW'(idx_q - XW'(1));

	assign ram_we    = cmd.clr_wr || cmd.add_wr;
	assign ram_waddr = cmd.clr_wr ? clr_q : node_addr;
	assign ram_wdata = cmd.clr_wr ? DATA_W'(clr_lb) : rdata + delta_q;

	ftp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_POSITIONS)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.add_rd || cmd.sum_rd),
		.raddr (node_addr),
		.rdata (rdata)
	);

	always_comb begin
		sts             = '0;
		sts.req_valid   = req.valid;
		sts.req_kind    = req.kind;
		sts.cur_kind    = kind_q;
		sts.clr_last    = (clr_q == AW'(MAX_POSITIONS - 1));
		sts.add_skip    = (idx_q == '0) || (idx_q > eff);
		sts.idx_zero    = (idx_q == '0);
		sts.rd_vld      = rd_vld_s1;
		sts.search_done = (lo_q > hi_q);
		sts.out_busy    = out_vld_q && !rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			rd_vld_s1 <= cmd.sum_rd;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q   <= req.kind;
			idx_q    <= (req.kind == KIND_QUERY) ? req_idx_sat : req_idx;
			delta_q  <= word_t'(req.delta);
			target_q <= word_t'(req.target_sum);
			lo_q     <= XW'(1);
			hi_q     <= eff;
			pos_q    <= '0;
			hit_q    <= 1'b0;
		end else if (cmd.find_mid) begin
			mid_q <= lo_hi >> 1;
			idx_q <= lo_hi >> 1;
		end else if (cmd.add_wr) begin
			idx_q <= idx_q + lb;
		end else if (cmd.sum_rd) begin
			idx_q <= idx_q - lb;
		end else if (cmd.find_cmp) begin
			if (acc_q == target_q) begin
				pos_q <= mid_q;
				hit_q <= 1'b1;
			end
			if ($signed(acc_q) < $signed(target_q)) begin
				lo_q <= mid_q + XW'(1);
			end else begin
				hi_q <= mid_q - XW'(1);
			end
		end

		// accumulate the node read in the previous cycle
		if (start || cmd.find_mid) begin
			acc_q <= '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q + rdata;
		end

		if (cmd.load_out) begin
			out_sum_q <= (kind_q == KIND_QUERY) ? acc_q : '0;
			out_idx_q <= hit_q ? IDX_W'(pos_q) : '0;
			out_hit_q <= hit_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.prefix_sum  = $signed(out_sum_q);
	assign rsp.found_index = out_idx_q;
	assign rsp.found       = out_hit_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_vld_q && !rsp.ready))
		else $error("result register overwritten before it was taken");

	a_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(cmd.sum_rd))
		else $error("accumulate without a prefix read");

	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && hit_q |-> pos_q != '0 && pos_q <= XW'(MAX_POSITIONS))
		else $error("hit reported at an impossible position");

endmodule

[rtl/fenwick_tree_prefix_sum_engine.sv]
// ----------------------------------------------------------------------------
// fenwick_tree_prefix_sum_engine
// Binary indexed tree over positions 1..min(active_size, MAX_POSITIONS): add, prefix sum, find.
//
//   port     dir   carries
//   req      in    kind, entry_index, delta, target_sum (valid/ready)
//   rsp      out   prefix_sum, found_index, found       (valid/ready)
//   apb      in    active_size at word 0 (psel/penable/pwrite/paddr/pwdata)
//
// Requests are handled one at a time; with L = log2(size):
//   add   : one node read and one node write per node climbed.
//   query : popcount(index) node reads.
//   find  : about L+1 search steps, each a prefix sum of mid and a compare.
// After reset a sweep writes every node before the first request beat is
// taken. A result waits in the output register while the next request
// beat is accepted.
// ----------------------------------------------------------------------------
module fenwick_tree_prefix_sum_engine #(
	parameter int MAX_POSITIONS = ftp_pkg::MAX_POSITIONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ftp_req_if.sink                     req,
	ftp_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ftp_pkg::APB_AW-1:0]  paddr,
	input  logic [ftp_pkg::APB_DW-1:0]  pwdata,
	output logic [ftp_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import ftp_pkg::*;

	idx_t     active_size_q;
	ftp_cmd_t cmd;
	ftp_sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACTIVE_SIZE) ? APB_DW'(active_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SIZE)) begin
			active_size_q <= pwdata[IDX_W-1:0];
		end
	end

	ftp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ftp_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_size (active_size_q),
		.cmd         (cmd),
		.sts         (sts),
		.req         (req),
		.rsp         (rsp)
	);

endmodule
